/* rtl/wnm_pkg.sv */
package wnm_pkg;

	// pattern storage and configuration port
	localparam int PATTERN_BYTES_DEF = 64;
	localparam int NUM_WORDS         = 8;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 64;

	// depth of the queues on either side of the matcher
	localparam int QUEUE_DEPTH = 2;

	// characters with a meaning of their own
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_QMARK   = 8'h3F;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_FILL    = 8'hFF;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_DIST  = 8'h20;

	// one classified name word, handed from the front to the matcher
	typedef struct packed {
		logic [7:0] fchar;
		logic       skip;
		logic       last;
		logic       empty;
	} char_item_t;

	// a..z to A..Z, everything else unchanged
	function automatic logic [7:0] fold_char(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			r = c - CASE_DIST;
		end
		return r;
	endfunction

endpackage

/* rtl/wildcard_name_match_top.sv */
// wildcard name matcher: a file name streams in one word per character
// (name_char, with last_char on its final character, or a lone empty_name
// word for a name with no characters) and one matched word comes out per
// name. the pattern is up to PATTERN_BYTES folded bytes written through the
// cfg port, eight bytes per register, lowest byte first, ending at the first
// zero byte. '?' takes any one character, '*' skips up to the first character
// equal to the byte after it (no backtracking), all compares ignore a..z
// case, and spaces and 0xff are skipped after the first character. the
// block takes one character per clock unless a pattern write holds it or
// an ending word meets a full result queue: the matcher updates its pattern
// window once per cycle, and a result shows in the result queue in the cycle
// after the ending word is accepted. both sides are two-deep queues, so one
// waiting result does not hold up the input. a cfg write is always accepted
// and holds the input while it lands, while the window reloads from the
// pattern and while it shifts once per position already consumed in the name
module wildcard_name_match_top #(
	parameter int PATTERN_BYTES = wnm_pkg::PATTERN_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// name characters
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     name_char,
	input  logic                           last_char,
	input  logic                           empty_name,
	// match results
	output logic                           empty,
	input  logic                           pop,
	output logic                           matched,
	// pattern registers
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wnm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wnm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wnm_pkg::*;

	char_item_t item;
	logic       item_valid;
	logic       item_take;
	logic       res_push;
	logic       res_match;
	logic       res_full;
	logic       cfg_wr;

	// pattern writes never stall
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// front: classify each word and queue it
	wnm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.name_char (name_char),
		.last_char (last_char),
		.empty_name(empty_name),
		.item_valid(item_valid),
		.item      (item),
		.item_take (item_take)
	);

	// back: pattern window, star scan and mismatch tracking
	wnm_back #(
		.PATTERN_BYTES(PATTERN_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_valid(item_valid),
		.item      (item),
		.item_take (item_take),
		.res_push  (res_push),
		.res_match (res_match),
		.res_full  (res_full)
	);

	// result queue, oldest result on the output
	wnm_fifo #(
		.WIDTH(1),
		.DEPTH(QUEUE_DEPTH)
	) u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_match),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(matched),
		.empty  (empty)
	);

endmodule

/* rtl/wnm_fifo.sv */
module wnm_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	// depth must be a power of two, which the block does not check; pointers then wrap on their own
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/wnm_front.sv */
module wnm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          name_char,
	input  logic                last_char,
	input  logic                empty_name,
	output logic                item_valid,
	output wnm_pkg::char_item_t item,
	input  logic                item_take
);
	import wnm_pkg::*;

	char_item_t in_item;
	logic       q_empty;

	// fold case and flag the characters that are skipped after the first character of a name
	always_comb begin
		in_item.fchar = fold_char(name_char);
		in_item.skip  = (name_char == CH_SPACE) || (name_char == CH_FILL);
		in_item.last  = last_char;
		in_item.empty = empty_name;
	end

	wnm_fifo #(
		.WIDTH($bits(char_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_iq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(in_item),
		.full   (full),
		.rd_en  (item_take),
		.rd_data(item),
		.empty  (q_empty)
	);

	assign item_valid = !q_empty;

endmodule

/* rtl/wnm_back.sv */
module wnm_back #(
	parameter int PATTERN_BYTES = wnm_pkg::PATTERN_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr,
	input  logic [wnm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wnm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             item_valid,
	input  wnm_pkg::char_item_t              item,
	output logic                             item_take,
	output logic                             res_push,
	output logic                             res_match,
	input  logic                             res_full
);
	import wnm_pkg::*;

	localparam int PAT_W  = PATTERN_BYTES * 8;
	localparam int PIDX_W = $clog2(PATTERN_BYTES + 1);

	// folded pattern as written, and the window starting at the current position
	logic [PAT_W-1:0]  pat_q;
	logic [PAT_W-1:0]  win_q;
	logic [PIDX_W-1:0] pidx_q;
	logic              star_q;
	logic              mism_q;
	logic              start_q;
	// realignment of the window after a pattern write
	logic              aln_busy_q;
	logic              aln_load_q;
	logic [PIDX_W-1:0] aln_cnt_q;

	logic [7:0]        pc;
	logic [7:0]        qc;
	logic              qhit;
	logic              adv1;
	logic              adv2;
	logic              star_n;
	logic              mism_n;
	logic              start_n;
	logic [PAT_W-1:0]  win_n;
	logic              ends;

	assign pc   = win_q[7:0];
	assign qc   = win_q[15:8];
	assign qhit = (qc != '0) && (item.fchar == qc);
	assign ends = item.empty || item.last;

	always_comb begin
		adv1    = 1'b0;
		adv2    = 1'b0;
		star_n  = star_q;
		mism_n  = mism_q;
		start_n = start_q;
		if (!item.empty && !mism_q) begin
			if (star_q) begin
				if (qhit) begin
					adv2   = 1'b1;
					star_n = 1'b0;
				end
			end else if (start_q || !item.skip) begin
				start_n = 1'b0;
				if (pc == '0) begin
					mism_n = 1'b1;
				end else if (pc == CH_STAR) begin
					if (qhit) begin
						adv2 = 1'b1;
					end else begin
						star_n = 1'b1;
					end
				end else if (pc == CH_QMARK || item.fchar == pc) begin
					adv1 = 1'b1;
				end else begin
					mism_n = 1'b1;
				end
			end
		end
		if (adv2) begin
			win_n = win_q >> 16;
		end else if (adv1) begin
			win_n = win_q >> 8;
		end else begin
			win_n = win_q;
		end
		res_match = !mism_n && (star_n ? (win_n[15:8] == '0) : (win_n[7:0] == '0));
	end

	// no word is taken in a cycle that writes the pattern
	assign item_take = item_valid && !cfg_wr && !aln_busy_q && (!ends || !res_full);
	assign res_push  = item_take && ends;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
		end else if (cfg_wr) begin
			for (int b = 0; b < PATTERN_BYTES; b++) begin
				if (cfg_index == CFG_IDX_W'(b >> 3)) begin
					pat_q[b*8 +: 8] <= fold_char(cfg_data[(b & 7)*8 +: 8]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			pidx_q     <= '0;
			star_q     <= 1'b0;
			mism_q     <= 1'b0;
			start_q    <= 1'b1;
			aln_busy_q <= 1'b0;
			aln_load_q <= 1'b0;
			aln_cnt_q  <= '0;
		end else if (cfg_wr) begin
			aln_busy_q <= 1'b1;
			aln_load_q <= 1'b1;
		end else if (aln_load_q) begin
			win_q      <= pat_q;
			aln_cnt_q  <= pidx_q;
			aln_load_q <= 1'b0;
			aln_busy_q <= (pidx_q != '0);
		end else if (aln_busy_q) begin
			win_q     <= win_q >> 8;
			aln_cnt_q <= aln_cnt_q - PIDX_W'(1);
			if (aln_cnt_q == PIDX_W'(1)) begin
				aln_busy_q <= 1'b0;
			end
		end else if (item_take) begin
			if (ends) begin
				win_q   <= pat_q;
				pidx_q  <= '0;
				star_q  <= 1'b0;
				mism_q  <= 1'b0;
				start_q <= 1'b1;
			end else begin
				win_q   <= win_n;
				star_q  <= star_n;
				mism_q  <= mism_n;
				start_q <= start_n;
				if (adv2) begin
					pidx_q <= pidx_q + PIDX_W'(2);
				end else if (adv1) begin
					pidx_q <= pidx_q + PIDX_W'(1);
				end
			end
		end
	end

endmodule

/* rtl/wnm_checker.sv */
module wnm_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop,
	input logic matched
);

	// a waiting result stays put until popped
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(matched))
		else $error("result word changed or vanished while not popped");

	// after reset the result queue is empty and the input queue is not full
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> empty && !full)
		else $error("queues not empty after reset");

	// the input queue only fills through a push
	a_full_by_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("input queue became full without a push");

endmodule

bind wildcard_name_match_top wnm_checker u_chk (.*);
